// ===== rtl/bsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types, constants and helpers of the bundle stream parser.
// ----------------------------------------------------------------------------
package bsp_pkg;

	localparam int PRIMARY_FIELDS = 11;
	localparam int MAX_SDNV_BYTES = 10;
	localparam int NUM_RES        = 4;

	localparam logic [4:0] ATTR_PROCFLAGS = 5'd0;
	localparam logic [4:0] ATTR_HDRLEN    = 5'd1;
	localparam logic [4:0] ATTR_FIELD0    = 5'd2;
	localparam logic [4:0] ATTR_DICTLEN   = 5'(PRIMARY_FIELDS + 2);
	localparam logic [4:0] ATTR_FRAGOFF   = 5'(PRIMARY_FIELDS + 3);
	localparam logic [4:0] ATTR_APPLEN    = 5'(PRIMARY_FIELDS + 4);
	localparam logic [4:0] ATTR_BLKFLAGS  = 5'(PRIMARY_FIELDS + 5);
	localparam logic [4:0] ATTR_REFCNT    = 5'(PRIMARY_FIELDS + 6);
	localparam logic [4:0] ATTR_REF       = 5'(PRIMARY_FIELDS + 7);
	localparam logic [4:0] ATTR_BLKLEN    = 5'(PRIMARY_FIELDS + 8);

	typedef enum logic [3:0] {
		PH_VER    = 4'd0,
		PH_FLAGS  = 4'd1,
		PH_HLEN   = 4'd2,
		PH_FIELDS = 4'd3,
		PH_DLEN   = 4'd4,
		PH_DICT   = 4'd5,
		PH_FOFF   = 4'd6,
		PH_ALEN   = 4'd7,
		PH_BTYPE  = 4'd8,
		PH_BFLAGS = 4'd9,
		PH_RCNT   = 4'd10,
		PH_REFS   = 4'd11,
		PH_BLEN   = 4'd12,
		PH_PAY    = 4'd13
	} phase_t;

	typedef enum logic [2:0] {
		EV_BEGIN      = 3'd0,
		EV_ATTR       = 3'd1,
		EV_DICT_BYTE  = 3'd2,
		EV_BLK_BEGIN  = 3'd3,
		EV_PAY_BYTE   = 3'd4,
		EV_PAY_END    = 3'd5,
		EV_BLK_END    = 3'd6,
		EV_BUNDLE_END = 3'd7
	} ev_code_t;

	typedef enum logic [1:0] {
		CFG_VERSION  = 2'd0,
		CFG_FRAG     = 2'd1,
		CFG_LASTBLK  = 2'd2,
		CFG_EIDREFS  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] expected_version;
		logic [7:0] fragment_mask;
		logic [7:0] last_block_mask;
		logic [7:0] eid_refs_mask;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [63:0] sdnv_accum;
		logic [3:0]  sdnv_bytes;
		logic [3:0]  field_index;
		logic [63:0] remaining;
		logic        is_fragment;
		logic        last_seen;
		logic [63:0] consumed;
	} state_t;

	typedef struct packed {
		logic [2:0]  code;
		logic        is_error;
		logic [4:0]  attribute;
		logic [63:0] value;
		logic [7:0]  data;
	} ev_t;

	function automatic ev_t mk_ev(input ev_code_t code, input logic err,
		input logic [4:0] attr, input logic [63:0] val, input logic [7:0] data);
		ev_t e;
		e.code      = code;
		e.is_error  = err;
		e.attribute = attr;
		e.value     = val;
		e.data      = data;
		return e;
	endfunction

endpackage

// ===== rtl/bsp_step.sv =====
// ----------------------------------------------------------------------------
// bsp_step
// Parse step for one stream byte: next parser state and up to four events.
// ----------------------------------------------------------------------------
module bsp_step import bsp_pkg::*; (
	input  state_t      cur,
	input  cfg_t        cfg,
	input  logic [7:0]  in_byte,
	input  logic        stream_end,
	output state_t      nxt,
	output ev_t         evs [NUM_RES],
	output logic [2:0]  n_ev
);

	typedef struct packed {
		logic        begin_ev;
		logic        blk_begin;
		logic        byte_ev;
		ev_code_t    byte_code;
		logic        attr_ev;
		logic [4:0]  attr_id;
		logic        finish;
		logic [63:0] finish_len;
		logic        close;
		logic        close_err;
	} act_t;

	act_t        act;
	logic [63:0] acc;
	logic [3:0]  bcnt;
	logic [3:0]  fi_n;
	logic [63:0] rem_dec;
	logic [63:0] refs_twice;

	assign acc        = {cur.sdnv_accum[56:0], in_byte[6:0]};
	assign bcnt       = cur.sdnv_bytes + 4'd1;
	assign fi_n       = cur.field_index + 4'd1;
	assign rem_dec    = cur.remaining - 64'd1;
	assign refs_twice = acc[63] ? '1 : {acc[62:0], 1'b0};

	// next state and decoded actions
	always_comb begin
		nxt = cur;
		act = '0;
		act.byte_code = EV_DICT_BYTE;
		if (stream_end) begin
			if (cur.phase != PH_VER) begin
				act.close     = 1'b1;
				act.close_err = (cur.phase < PH_BTYPE);
			end
		end else if (cur.phase == PH_VER) begin
			nxt.consumed = 64'd1;
			act.begin_ev = 1'b1;
			if (in_byte != cfg.expected_version) begin
				act.close     = 1'b1;
				act.close_err = 1'b1;
			end else begin
				nxt.phase       = PH_FLAGS;
				nxt.sdnv_accum  = '0;
				nxt.sdnv_bytes  = '0;
				nxt.is_fragment = 1'b0;
				nxt.last_seen   = 1'b0;
			end
		end else begin
			nxt.consumed = cur.consumed + 64'd1;
			unique case (cur.phase)
				PH_DICT: begin
					act.byte_ev   = 1'b1;
					act.byte_code = EV_DICT_BYTE;
					nxt.remaining = rem_dec;
					if (rem_dec == '0)
						nxt.phase = cur.is_fragment ? PH_FOFF : PH_BTYPE;
				end
				PH_BTYPE: begin
					act.blk_begin  = 1'b1;
					nxt.last_seen  = 1'b0;
					nxt.sdnv_accum = '0;
					nxt.sdnv_bytes = '0;
					nxt.phase      = PH_BFLAGS;
				end
				PH_PAY: begin
					act.byte_ev   = 1'b1;
					act.byte_code = EV_PAY_BYTE;
					nxt.remaining = rem_dec;
					if (rem_dec == '0) begin
						act.finish     = 1'b1;
						act.finish_len = cur.sdnv_accum;
						if (cur.last_seen)
							act.close = 1'b1;
						else
							nxt.phase = PH_BTYPE;
					end
				end
				default: begin
					// SDNV byte: shift in seven bits, act on the closing byte
					if (in_byte[7]) begin
						nxt.sdnv_accum = acc;
						nxt.sdnv_bytes = bcnt;
						if (bcnt >= 4'(MAX_SDNV_BYTES)) begin
							act.close     = 1'b1;
							act.close_err = 1'b1;
						end
					end else begin
						nxt.sdnv_accum = '0;
						nxt.sdnv_bytes = '0;
						act.attr_ev    = 1'b1;
						unique case (cur.phase)
							PH_FLAGS: begin
								act.attr_id     = ATTR_PROCFLAGS;
								nxt.is_fragment = |(acc[7:0] & cfg.fragment_mask);
								nxt.phase       = PH_HLEN;
							end
							PH_HLEN: begin
								act.attr_id     = ATTR_HDRLEN;
								nxt.field_index = '0;
								nxt.phase       = PH_FIELDS;
							end
							PH_FIELDS: begin
								act.attr_id     = ATTR_FIELD0 + 5'(cur.field_index);
								nxt.field_index = fi_n;
								if (fi_n >= 4'(PRIMARY_FIELDS) || fi_n == '0)
									nxt.phase = PH_DLEN;
							end
							PH_DLEN: begin
								act.attr_id   = ATTR_DICTLEN;
								nxt.remaining = acc;
								if (acc != '0)
									nxt.phase = PH_DICT;
								else
									nxt.phase = cur.is_fragment ? PH_FOFF : PH_BTYPE;
							end
							PH_FOFF: begin
								act.attr_id = ATTR_FRAGOFF;
								nxt.phase   = PH_ALEN;
							end
							PH_ALEN: begin
								act.attr_id = ATTR_APPLEN;
								nxt.phase   = PH_BTYPE;
							end
							PH_BFLAGS: begin
								act.attr_id   = ATTR_BLKFLAGS;
								nxt.last_seen = |(acc[7:0] & cfg.last_block_mask);
								nxt.phase     = |(acc[7:0] & cfg.eid_refs_mask) ?
									PH_RCNT : PH_BLEN;
							end
							PH_RCNT: begin
								act.attr_id   = ATTR_REFCNT;
								nxt.remaining = refs_twice;
								nxt.phase     = (refs_twice != '0) ? PH_REFS : PH_BLEN;
							end
							PH_REFS: begin
								act.attr_id   = ATTR_REF;
								nxt.remaining = rem_dec;
								if (rem_dec == '0)
									nxt.phase = PH_BLEN;
							end
							PH_BLEN: begin
								act.attr_id    = ATTR_BLKLEN;
								nxt.sdnv_accum = acc;
								nxt.remaining  = acc;
								if (acc != '0) begin
									nxt.phase = PH_PAY;
								end else begin
									act.finish     = 1'b1;
									act.finish_len = acc;
									if (cur.last_seen)
										act.close = 1'b1;
									else
										nxt.phase = PH_BTYPE;
								end
							end
							default: begin
								act.attr_ev = 1'b0;
								nxt.phase   = PH_VER;
							end
						endcase
					end
				end
			endcase
		end
		// closing the bundle drops any partial SDNV
		if (act.close) begin
			nxt.phase      = PH_VER;
			nxt.sdnv_accum = '0;
			nxt.sdnv_bytes = '0;
		end
	end

	// event list in emission order
	always_comb begin
		evs  = '{default: '0};
		n_ev = '0;
		if (act.begin_ev) begin
			evs[n_ev[1:0]] = mk_ev(EV_BEGIN, 1'b0, 5'd0, {56'd0, in_byte}, 8'd0);
			n_ev = n_ev + 3'd1;
		end
		if (act.blk_begin) begin
			evs[n_ev[1:0]] = mk_ev(EV_BLK_BEGIN, 1'b0, 5'd0, {56'd0, in_byte}, 8'd0);
			n_ev = n_ev + 3'd1;
		end
		if (act.byte_ev) begin
			evs[n_ev[1:0]] = mk_ev(act.byte_code, 1'b0, 5'd0, 64'd0, in_byte);
			n_ev = n_ev + 3'd1;
		end
		if (act.attr_ev) begin
			evs[n_ev[1:0]] = mk_ev(EV_ATTR, 1'b0, act.attr_id, acc, 8'd0);
			n_ev = n_ev + 3'd1;
		end
		if (act.finish) begin
			evs[n_ev[1:0]] = mk_ev(EV_PAY_END, 1'b0, 5'd0, act.finish_len, 8'd0);
			n_ev = n_ev + 3'd1;
			evs[n_ev[1:0]] = mk_ev(EV_BLK_END, 1'b0, 5'd0, 64'd0, 8'd0);
			n_ev = n_ev + 3'd1;
		end
		if (act.close) begin
			evs[n_ev[1:0]] = mk_ev(EV_BUNDLE_END, act.close_err, 5'd0, nxt.consumed, 8'd0);
			n_ev = n_ev + 3'd1;
		end
	end

endmodule

// ===== rtl/bundle_stream_parser.sv =====
// ----------------------------------------------------------------------------
// bundle_stream_parser
// Byte-serial bundle parser: primary block, extension and payload blocks,
// one parse event per output transfer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | in        | in_valid/in_stall  | in_byte, stream_end
//  out     | out       | out_valid/out_stall| event_res, is_error, attribute,
//          |           |                    | field_value, data_out, last
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//
//  A byte is parsed in the cycle of its transfer; its events land in a
//  four-entry result buffer and leave one per cycle while out_stall is low.
//  A byte causing several events holds the input until its final event
//  leaves, so bytes with no or one event sustain one per cycle while the
//  output is not stalled.
//  The next byte is taken in the cycle the final event of the previous one
//  leaves, so stalls on the output pass straight back to in_stall.
//  Reset clears parser state, the buffer count and pointer and the registers
//  to their defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module bundle_stream_parser import bsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        stream_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic        is_error,
	output logic [4:0]  attribute,
	output logic [63:0] field_value,
	output logic [7:0]  data_out,
	output logic        last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	state_t      state_q;
	state_t      state_nxt;
	cfg_t        cfg_q;
	ev_t         evbuf_q [NUM_RES];
	ev_t         evs [NUM_RES];
	logic [2:0]  n_ev;
	logic [2:0]  pend_q;
	logic [1:0]  rd_q;
	logic        in_take;
	logic        out_take;

	bsp_step u_step (
		.cur        (state_q),
		.cfg        (cfg_q),
		.in_byte    (in_byte),
		.stream_end (stream_end),
		.nxt        (state_nxt),
		.evs        (evs),
		.n_ev       (n_ev)
	);

	assign out_valid = (pend_q != '0);
	assign out_take  = out_valid && !out_stall;
	assign in_stall  = out_valid && !(out_take && pend_q == 3'd1);
	assign in_take   = in_valid && !in_stall;

	assign event_res   = evbuf_q[rd_q].code;
	assign is_error    = evbuf_q[rd_q].is_error;
	assign attribute   = evbuf_q[rd_q].attribute;
	assign field_value = evbuf_q[rd_q].value;
	assign data_out    = evbuf_q[rd_q].data;
	assign last        = (pend_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version <= 8'd6;
			cfg_q.fragment_mask    <= 8'd1;
			cfg_q.last_block_mask  <= 8'd8;
			cfg_q.eid_refs_mask    <= 8'd64;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_VERSION: cfg_q.expected_version <= cfg_data;
				CFG_FRAG:    cfg_q.fragment_mask    <= cfg_data;
				CFG_LASTBLK: cfg_q.last_block_mask  <= cfg_data;
				CFG_EIDREFS: cfg_q.eid_refs_mask    <= cfg_data;
				default:     cfg_q.eid_refs_mask    <= cfg_q.eid_refs_mask;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= PH_VER;
			state_q.sdnv_accum  <= '0;
			state_q.sdnv_bytes  <= '0;
			state_q.field_index <= '0;
			state_q.remaining   <= '0;
			state_q.is_fragment <= 1'b0;
			state_q.last_seen   <= 1'b0;
			state_q.consumed    <= '0;
		end else if (in_take) begin
			state_q <= state_nxt;
		end
	end

	// a new transfer reloads the buffer, otherwise advance the read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			rd_q   <= '0;
		end else if (in_take) begin
			pend_q <= n_ev;
			rd_q   <= '0;
		end else if (out_take) begin
			pend_q <= pend_q - 3'd1;
			rd_q   <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take)
			evbuf_q <= evs;
	end

endmodule

// ===== rtl/bsp_checker.sv =====
// ----------------------------------------------------------------------------
// bsp_checker
// Port-level checks of the bundle stream parser, bound to the top level.
// ----------------------------------------------------------------------------
module bsp_checker import bsp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  event_res,
	input logic        is_error,
	input logic [4:0]  attribute,
	input logic [63:0] field_value,
	input logic [7:0]  data_out,
	input logic        last
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res)
			&& $stable(is_error) && $stable(attribute)
			&& $stable(field_value) && $stable(data_out) && $stable(last))
		else $error("stalled result changed");

	// more events of the same byte follow a non-final transfer
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("event burst cut short");

	// a byte is taken only once the previous byte's events are gone
	a_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> !out_valid || (!out_stall && last))
		else $error("input taken with events pending");

	// errors are flagged only on bundle end
	a_err_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_error |-> event_res == EV_BUNDLE_END)
		else $error("error flag outside bundle end");

endmodule

bind bundle_stream_parser bsp_checker u_bsp_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bundle stream parser. Generated bundles, mostly
// well formed with random content, plus broken ones (bad version, truncated
// streams, over-long SDNVs), are fed byte by byte under random idle and stall.
// A parse-event predictor follows every accepted byte and each output transfer
// is compared against the oldest predicted event.
// ----------------------------------------------------------------------------
import bsp_pkg::*;

localparam logic [4:0] NO_ATTR = 5'd0;

class parse_event_board;
	typedef struct packed {
		ev_t  ev;
		logic last;
	} exp_ev_t;

	cfg_t        regs;
	phase_t      phase;
	logic [63:0] accum;
	logic [63:0] remaining;
	logic [63:0] consumed;
	logic [3:0]  sdnv_cnt;
	logic [3:0]  field_idx;
	logic        frag_flag;
	logic        last_flag;
	exp_ev_t     expected_events[$];
	exp_ev_t     step_events[$];
	int          mismatches;

	function new();
		regs.expected_version = 8'd6;
		regs.fragment_mask    = 8'd1;
		regs.last_block_mask  = 8'd8;
		regs.eid_refs_mask    = 8'd64;
		phase      = PH_VER;
		accum      = '0;
		remaining  = '0;
		consumed   = '0;
		sdnv_cnt   = '0;
		field_idx  = '0;
		frag_flag  = 1'b0;
		last_flag  = 1'b0;
		mismatches = 0;
	endfunction

	function void write_reg(cfg_idx_t idx, logic [7:0] d);
		case (idx)
			CFG_VERSION: regs.expected_version = d;
			CFG_FRAG:    regs.fragment_mask    = d;
			CFG_LASTBLK: regs.last_block_mask  = d;
			CFG_EIDREFS: regs.eid_refs_mask    = d;
		endcase
	endfunction

	function int pending();
		return expected_events.size();
	endfunction

	function void emit(ev_code_t code, logic err, logic [4:0] attr, logic [63:0] val,
		logic [7:0] data);
		exp_ev_t x;
		x.ev.code      = code;
		x.ev.is_error  = err;
		x.ev.attribute = attr;
		x.ev.value     = val;
		x.ev.data      = data;
		x.last         = 1'b0;
		if (step_events.size() < NUM_RES) step_events.push_back(x);
	endfunction

	function void close_bundle(logic err);
		emit(EV_BUNDLE_END, err, NO_ATTR, consumed, 8'd0);
		phase    = PH_VER;
		accum    = '0;
		sdnv_cnt = '0;
	endfunction

	function void after_dict();
		phase = frag_flag ? PH_FOFF : PH_BTYPE;
	endfunction

	function void finish_block();
		emit(EV_PAY_END, 1'b0, NO_ATTR, accum, 8'd0);
		emit(EV_BLK_END, 1'b0, NO_ATTR, 64'd0, 8'd0);
		if (last_flag) close_bundle(1'b0);
		else phase = PH_BTYPE;
	endfunction

	function void sdnv_done(logic [63:0] v);
		case (phase)
			PH_FLAGS: begin
				emit(EV_ATTR, 1'b0, ATTR_PROCFLAGS, v, 8'd0);
				frag_flag = (v[7:0] & regs.fragment_mask) != 0;
				phase = PH_HLEN;
			end
			PH_HLEN: begin
				emit(EV_ATTR, 1'b0, ATTR_HDRLEN, v, 8'd0);
				field_idx = '0;
				phase = PH_FIELDS;
			end
			PH_FIELDS: begin
				emit(EV_ATTR, 1'b0, ATTR_FIELD0 + 5'(field_idx), v, 8'd0);
				field_idx = field_idx + 4'd1;
				if (field_idx >= PRIMARY_FIELDS || field_idx == 0) phase = PH_DLEN;
			end
			PH_DLEN: begin
				emit(EV_ATTR, 1'b0, ATTR_DICTLEN, v, 8'd0);
				remaining = v;
				if (v == 0) after_dict();
				else phase = PH_DICT;
			end
			PH_FOFF: begin
				emit(EV_ATTR, 1'b0, ATTR_FRAGOFF, v, 8'd0);
				phase = PH_ALEN;
			end
			PH_ALEN: begin
				emit(EV_ATTR, 1'b0, ATTR_APPLEN, v, 8'd0);
				phase = PH_BTYPE;
			end
			PH_BFLAGS: begin
				emit(EV_ATTR, 1'b0, ATTR_BLKFLAGS, v, 8'd0);
				last_flag = (v[7:0] & regs.last_block_mask) != 0;
				phase = ((v[7:0] & regs.eid_refs_mask) != 0) ? PH_RCNT : PH_BLEN;
			end
			PH_RCNT: begin
				emit(EV_ATTR, 1'b0, ATTR_REFCNT, v, 8'd0);
				// twice the count, pinned at all ones
				remaining = (v > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : v << 1;
				phase = (remaining != 0) ? PH_REFS : PH_BLEN;
			end
			PH_REFS: begin
				emit(EV_ATTR, 1'b0, ATTR_REF, v, 8'd0);
				remaining = remaining - 64'd1;
				if (remaining == 0) phase = PH_BLEN;
			end
			PH_BLEN: begin
				emit(EV_ATTR, 1'b0, ATTR_BLKLEN, v, 8'd0);
				accum = v;
				remaining = v;
				if (v == 0) finish_block();
				else phase = PH_PAY;
			end
			default: phase = PH_VER;
		endcase
	endfunction

	// Predict the events of one accepted input transfer.
	function void parse_byte(logic [7:0] b, logic e);
		logic [63:0] v;
		step_events.delete();
		if (e) begin
			if (phase != PH_VER) close_bundle(phase < PH_BTYPE);
		end else if (phase == PH_VER) begin
			consumed = 64'd1;
			emit(EV_BEGIN, 1'b0, NO_ATTR, {56'd0, b}, 8'd0);
			if (b != regs.expected_version) begin
				close_bundle(1'b1);
			end else begin
				phase     = PH_FLAGS;
				accum     = '0;
				sdnv_cnt  = '0;
				frag_flag = 1'b0;
				last_flag = 1'b0;
			end
		end else begin
			consumed = consumed + 64'd1;
			case (phase)
				PH_DICT: begin
					emit(EV_DICT_BYTE, 1'b0, NO_ATTR, 64'd0, b);
					remaining = remaining - 64'd1;
					if (remaining == 0) after_dict();
				end
				PH_BTYPE: begin
					emit(EV_BLK_BEGIN, 1'b0, NO_ATTR, {56'd0, b}, 8'd0);
					last_flag = 1'b0;
					accum     = '0;
					sdnv_cnt  = '0;
					phase     = PH_BFLAGS;
				end
				PH_PAY: begin
					emit(EV_PAY_BYTE, 1'b0, NO_ATTR, 64'd0, b);
					remaining = remaining - 64'd1;
					if (remaining == 0) finish_block();
				end
				default: begin
					accum = {accum[56:0], b[6:0]};
					sdnv_cnt = sdnv_cnt + 4'd1;
					if (b[7]) begin
						if (sdnv_cnt >= MAX_SDNV_BYTES) close_bundle(1'b1);
					end else begin
						v = accum;
						accum = '0;
						sdnv_cnt = '0;
						sdnv_done(v);
					end
				end
			endcase
		end
		if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
		foreach (step_events[i]) expected_events.push_back(step_events[i]);
	endfunction

	function void check_event(logic [2:0] code, logic err, logic [4:0] attr,
		logic [63:0] val, logic [7:0] data, logic fin);
		exp_ev_t want;
		if (expected_events.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected event: ev=%0d err=%0d attr=%0d val=%0h data=%0h last=%0d",
					code, err, attr, val, data, fin);
			return;
		end
		want = expected_events.pop_front();
		if ({want.ev, want.last} !== {code, err, attr, val, data, fin}) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch: expected ev=%0d err=%0d attr=%0d val=%0h data=%0h last=%0d",
					want.ev.code, want.ev.is_error, want.ev.attribute, want.ev.value,
					want.ev.data, want.last);
				$display("          actual   ev=%0d err=%0d attr=%0d val=%0h data=%0h last=%0d",
					code, err, attr, val, data, fin);
			end
		end
	endfunction
endclass

module tb_top;
	typedef struct packed {
		logic [7:0] b;
		logic       e;
	} stim_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = '0;
	logic        stream_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  event_res;
	logic        is_error;
	logic [4:0]  attribute;
	logic [63:0] field_value;
	logic [7:0]  data_out;
	logic        last;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_VERSION;
	logic [7:0]  cfg_data = '0;

	parse_event_board sb;
	stim_t            stim_q[$];
	int               sdnv_slot;
	int               long_at;
	bit               in_calm = 1'b0;
	bit               out_calm = 1'b1;

	bundle_stream_parser u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.stream_end  (stream_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_res   (event_res),
		.is_error    (is_error),
		.attribute   (attribute),
		.field_value (field_value),
		.data_out    (data_out),
		.last        (last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #4 clk = ~clk;

	// Byte in first; its own events leave at later edges, so queue order holds.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.parse_byte(in_byte, stream_end);
			if (out_valid === 1'b1 && !out_stall)
				sb.check_event(event_res, is_error, attribute, field_value, data_out, last);
		end
	end

	function automatic void push_byte(logic [7:0] b);
		stim_q.push_back('{b, 1'b0});
	endfunction

	function automatic void push_end();
		stim_q.push_back('{8'($urandom), 1'b1});
	endfunction

	// Mostly short values, now and then anything up to 64 bits.
	function automatic logic [63:0] rand_word();
		if ($urandom_range(0, 3) == 0)
			return {$urandom, $urandom} >> $urandom_range(0, 63);
		return 64'($urandom_range(0, 16383));
	endfunction

	// Minimal encoding, now and then padded with leading empty groups.
	function automatic void push_sdnv(logic [63:0] v);
		int n;
		int pad;
		n = 1;
		while (n < MAX_SDNV_BYTES && (v >> (7 * n)) != 0) n++;
		pad = (n < MAX_SDNV_BYTES && $urandom_range(0, 7) == 0) ?
			$urandom_range(1, MAX_SDNV_BYTES - n) : 0;
		repeat (pad) push_byte(8'h80);
		for (int i = n - 1; i >= 0; i--) push_byte({i != 0, 7'(v >> (7 * i))});
	endfunction

	// Random groups; ten of them may overflow 64 bits.
	function automatic void push_junk_sdnv();
		int n;
		n = $urandom_range(1, MAX_SDNV_BYTES);
		for (int i = 0; i < n; i++) push_byte({i != n - 1, 7'($urandom)});
	endfunction

	function automatic void push_long_sdnv();
		repeat (MAX_SDNV_BYTES) push_byte({1'b1, 7'($urandom)});
	endfunction

	// Returns 1 when the field was replaced by an over-long SDNV: stop the bundle.
	function automatic bit add_field(logic [63:0] v, bit exact);
		sdnv_slot++;
		if (sdnv_slot == long_at) begin
			push_long_sdnv();
			return 1'b1;
		end
		if (exact) push_sdnv(v);
		else push_junk_sdnv();
		return 1'b0;
	endfunction

	function automatic void gen_bundle();
		int          kind;
		int          start;
		int          cut;
		int          n_blocks;
		int          dict_len;
		logic [63:0] flags;
		logic [63:0] refs_cnt;
		logic [63:0] blk_len;
		logic [7:0]  eid_m;
		logic [7:0]  last_m;
		bit          frag;
		bit          with_refs;
		bit          is_last;
		kind   = $urandom_range(0, 19);
		start  = stim_q.size();
		eid_m  = sb.regs.eid_refs_mask;
		last_m = sb.regs.last_block_mask;
		sdnv_slot = 0;
		long_at = (kind == 1 || kind == 2) ? $urandom_range(1, 24) : 0;
		if (kind == 0) begin
			push_byte(sb.regs.expected_version ^ (8'd1 << $urandom_range(0, 7)));
			return;
		end
		if (kind == 19) begin
			repeat (3) push_byte(8'($urandom));
			push_end();
			return;
		end
		push_byte(sb.regs.expected_version);
		flags = 64'($urandom_range(0, 1023));
		if ($urandom_range(0, 2) == 0) flags[7:0] |= sb.regs.fragment_mask;
		else flags[7:0] &= ~sb.regs.fragment_mask;
		frag = (flags[7:0] & sb.regs.fragment_mask) != 0;
		if (add_field(flags, 1'b1)) return;
		if (add_field(64'($urandom_range(0, 400)), $urandom_range(0, 3) != 0)) return;
		repeat (PRIMARY_FIELDS)
			if (add_field(rand_word(), $urandom_range(0, 2) != 0)) return;
		dict_len = $urandom_range(0, 4);
		if (add_field(64'(dict_len), 1'b1)) return;
		repeat (dict_len) push_byte(8'($urandom));
		if (frag) begin
			if (add_field(rand_word(), $urandom_range(0, 1) != 0)) return;
			if (add_field(rand_word(), $urandom_range(0, 1) != 0)) return;
		end
		n_blocks = $urandom_range(1, 3);
		is_last = 1'b0;
		for (int blk = 0; blk < n_blocks; blk++) begin
			push_byte(8'($urandom));
			flags = 64'($urandom_range(0, 255));
			if ($urandom_range(0, 1)) flags[7:0] |= eid_m;
			else flags[7:0] &= ~eid_m;
			if (blk == n_blocks - 1 && $urandom_range(0, 4) != 0) flags[7:0] |= last_m;
			else flags[7:0] &= ~last_m;
			with_refs = (flags[7:0] & eid_m) != 0;
			is_last   = (flags[7:0] & last_m) != 0;
			if (add_field(flags, 1'b1)) return;
			if (with_refs) begin
				if ($urandom_range(0, 11) == 0) begin
					// count too large to double: send a few references, then cut
					refs_cnt = rand_word();
					refs_cnt[63] = 1'b1;
					if (add_field(refs_cnt, 1'b1)) return;
					repeat (3) if (add_field(rand_word(), 1'b1)) return;
					push_end();
					return;
				end
				refs_cnt = 64'($urandom_range(0, 2));
				if (add_field(refs_cnt, 1'b1)) return;
				repeat (2 * refs_cnt)
					if (add_field(rand_word(), $urandom_range(0, 1) != 0)) return;
			end
			blk_len = 64'($urandom_range(0, 6));
			if (add_field(blk_len, 1'b1)) return;
			repeat (blk_len) push_byte(8'($urandom));
		end
		if (!is_last) push_end();
		if ((kind == 3 || kind == 4) && stim_q.size() - start > 1) begin
			cut = $urandom_range(start + 1, stim_q.size() - 1);
			while (stim_q.size() > cut) void'(stim_q.pop_back());
			push_end();
		end
	endfunction

	task automatic send_stimulus();
		int    gap;
		stim_t s;
		while (stim_q.size() > 0) begin
			s = stim_q.pop_front();
			if ($urandom_range(0, 24) == 0) in_calm = !in_calm;
			gap = in_calm ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid   <= 1'b1;
			in_byte    <= s.b;
			stream_end <= s.e;
			do @(posedge clk); while (in_stall);
		end
		in_valid <= 1'b0;
	endtask

	// Let the last byte be predicted, wait for every predicted event, then let
	// any byte without events settle.
	task automatic settle();
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_config(logic [7:0] ver, logic [7:0] frag_m, logic [7:0] last_m,
		logic [7:0] eid_m);
		cfg_idx_t   idx_list[4];
		logic [7:0] vals[4];
		idx_list = '{CFG_VERSION, CFG_FRAG, CFG_LASTBLK, CFG_EIDREFS};
		vals     = '{ver, frag_m, last_m, eid_m};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx_list[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			sb.write_reg(idx_list[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// Hold each phase to n_items transfers: cut the tail bundle and end the stream.
	task automatic run_phase(int n_items);
		while (stim_q.size() < n_items) gen_bundle();
		if (stim_q.size() > n_items) begin
			while (stim_q.size() >= n_items) void'(stim_q.pop_back());
			push_end();
		end
		send_stimulus();
		settle();
	endtask

	initial begin : result_sink
		int hold;
		forever begin
			if ($urandom_range(0, 24) == 0) out_calm = !out_calm;
			hold = out_calm ? 0 : $urandom_range(0, 13);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// end while idle, bad versions at both extremes, over-long SDNV,
		// end inside the primary block
		push_end();
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(sb.regs.expected_version);
		push_long_sdnv();
		push_byte(sb.regs.expected_version);
		push_byte(8'h00);
		push_end();
		send_stimulus();
		settle();

		run_phase(42);
		write_config(8'hFF, 8'hFF, 8'h80, 8'h01);
		run_phase(42);
		write_config(8'h00, 8'h00, 8'h00, 8'h00);
		run_phase(42);
		write_config(8'($urandom_range(0, 255)), 8'd1 << $urandom_range(0, 7), 8'hFF, 8'hFF);
		run_phase(42);
		write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		run_phase(42);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Mismatches found");
		$finish;
	end
endmodule
